### src/json_value_skipper_assert.svh
// Assertion macros shared by the json value skipper modules.
// Depends on nothing; included by files that check their own logic.
`ifndef JSON_VALUE_SKIPPER_ASSERT_SVH
`define JSON_VALUE_SKIPPER_ASSERT_SVH

`ifndef SYNTHESIS
`define JVS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("json_value_skipper: check failed");
`define JVS_ASSERT_RST(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) !rst_n |=> prop) \
    else $error("json_value_skipper: reset check failed");
`else
`define JVS_ASSERT(lbl, clk, rst_n, prop)
`define JVS_ASSERT_RST(lbl, clk, rst_n, prop)
`endif

`endif

### src/jvs_pkg.sv
// Shared types and constants of the json value skipper.
// Depends on nothing; imported by every module of the block.
package jvs_pkg;

  localparam int DEF_MAX_NEST_DEPTH = 255;
  localparam int QUEUE_DEPTH        = 2;

  localparam logic [7:0] CHAR_NUL     = 8'h00;
  localparam logic [7:0] CHAR_TAB     = 8'h09;
  localparam logic [7:0] CHAR_LF      = 8'h0a;
  localparam logic [7:0] CHAR_CR      = 8'h0d;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_QUOTE   = 8'h22;
  localparam logic [7:0] CHAR_COMMA   = 8'h2c;
  localparam logic [7:0] CHAR_LSQ     = 8'h5b;
  localparam logic [7:0] CHAR_BSLASH  = 8'h5c;
  localparam logic [7:0] CHAR_RSQ     = 8'h5d;
  localparam logic [7:0] CHAR_F       = 8'h66;
  localparam logic [7:0] CHAR_N       = 8'h6e;
  localparam logic [7:0] CHAR_T       = 8'h74;
  localparam logic [7:0] CHAR_LCURLY  = 8'h7b;
  localparam logic [7:0] CHAR_RCURLY  = 8'h7d;

  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_STRING = 3'd1;
  localparam logic [2:0] KIND_ARRAY  = 3'd2;
  localparam logic [2:0] KIND_OBJECT = 3'd3;
  localparam logic [2:0] KIND_TRUE   = 3'd4;
  localparam logic [2:0] KIND_FALSE  = 3'd5;
  localparam logic [2:0] KIND_NULL   = 3'd6;
  localparam logic [2:0] KIND_NUMBER = 3'd7;

  typedef enum logic [3:0] {
    CLS_NUL,
    CLS_SPACE,
    CLS_QUOTE,
    CLS_BSLASH,
    CLS_OPEN_SQ,
    CLS_OPEN_CURLY,
    CLS_CLOSE_SQ,
    CLS_CLOSE_CURLY,
    CLS_COMMA,
    CLS_LIT_T,
    CLS_LIT_F,
    CLS_LIT_N,
    CLS_OTHER
  } byte_class_e;

  typedef struct packed {
    logic       consumed;
    logic       done;
    logic [2:0] kind;
    logic       ovf;
  } jvs_result_t;

endpackage

### src/jvs_front.sv
// Front stage: accept a text word, classify the byte and register its class.
// Depends on jvs_pkg.
module jvs_front import jvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  text_byte_i,
  output logic        cls_valid_o,
  input  logic        cls_ready_i,
  output byte_class_e cls_o
);

  logic        valid_q, valid_d;
  byte_class_e cls_q, cls_d;
  byte_class_e cls_now;

  always_comb begin
    unique case (text_byte_i)
      CHAR_NUL:                            cls_now = CLS_NUL;
      CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_CR: cls_now = CLS_SPACE;
      CHAR_QUOTE:                          cls_now = CLS_QUOTE;
      CHAR_BSLASH:                         cls_now = CLS_BSLASH;
      CHAR_LSQ:                            cls_now = CLS_OPEN_SQ;
      CHAR_LCURLY:                         cls_now = CLS_OPEN_CURLY;
      CHAR_RSQ:                            cls_now = CLS_CLOSE_SQ;
      CHAR_RCURLY:                         cls_now = CLS_CLOSE_CURLY;
      CHAR_COMMA:                          cls_now = CLS_COMMA;
      CHAR_T:                              cls_now = CLS_LIT_T;
      CHAR_F:                              cls_now = CLS_LIT_F;
      CHAR_N:                              cls_now = CLS_LIT_N;
      default:                             cls_now = CLS_OTHER;
    endcase
  end

  assign in_ready_o = !valid_q || cls_ready_i;

  always_comb begin
    valid_d = valid_q;
    cls_d   = cls_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
      if (in_valid_i) begin
        cls_d = cls_now;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cls_q <= cls_d;
  end

  assign cls_valid_o = valid_q;
  assign cls_o       = cls_q;

endmodule

### src/jvs_queue.sv
// Short queue of byte classes between the front and back stages.
// Depends on jvs_pkg and json_value_skipper_assert.svh.
`include "json_value_skipper_assert.svh"
module jvs_queue import jvs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_valid_i,
  output logic        push_ready_o,
  input  byte_class_e push_cls_i,
  output logic        pop_valid_o,
  input  logic        pop_ready_i,
  output byte_class_e pop_cls_o
);

  localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

  byte_class_e     mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign push_ready_o = (count_q != FullCnt);
  assign pop_valid_o  = (count_q != '0);
  assign pop_cls_o    = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    priority if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end else begin
      count_d = count_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_cls_i;
    end
  end

  `JVS_ASSERT(a_count_bound, clk_i, rst_ni, count_q <= FullCnt)
  `JVS_ASSERT(a_count_step, clk_i, rst_ni,
    (push && !pop) |=> count_q == $past(count_q) + 1'b1)

endmodule

### src/jvs_back.sv
// Back stage: run the value-skipping state machine on byte classes and
// register one result word per class. Depends on jvs_pkg and the assert header.
`include "json_value_skipper_assert.svh"
module jvs_back import jvs_pkg::*; #(
  parameter int MAX_NEST_DEPTH = DEF_MAX_NEST_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cls_valid_i,
  output logic        cls_ready_o,
  input  byte_class_e cls_i,
  output logic        res_valid_o,
  input  logic        res_ready_i,
  output jvs_result_t res_o
);

  localparam int DepthW = $clog2(MAX_NEST_DEPTH + 1);
  localparam logic [DepthW-1:0] DepthMax = DepthW'(MAX_NEST_DEPTH);
  localparam logic [DepthW-1:0] DepthOne = DepthW'(1);

  localparam logic [2:0] PH_IDLE   = 3'd0;
  localparam logic [2:0] PH_STR    = 3'd1;
  localparam logic [2:0] PH_BRK    = 3'd2;
  localparam logic [2:0] PH_BRKSTR = 3'd3;
  localparam logic [2:0] PH_LIT    = 3'd4;
  localparam logic [2:0] PH_NUM    = 3'd5;

  logic [2:0]        phase_q, phase_d;
  logic              esc_q, esc_d;
  logic [DepthW-1:0] depth_q, depth_d;
  logic              curly_q, curly_d;
  logic [2:0]        lit_q, lit_d;
  logic [2:0]        kind_q, kind_d;
  logic              ovf_q, ovf_d;
  logic              out_valid_q;
  jvs_result_t       out_q, res_now;
  logic              take;
  logic              is_open, is_close;
  logic [2:0]        lit_dec;
  logic [DepthW-1:0] depth_dec;

  assign cls_ready_o = !out_valid_q || res_ready_i;
  assign take        = cls_valid_i && cls_ready_o;

  assign is_open  = curly_q ? (cls_i == CLS_OPEN_CURLY) : (cls_i == CLS_OPEN_SQ);
  assign is_close = curly_q ? (cls_i == CLS_CLOSE_CURLY) : (cls_i == CLS_CLOSE_SQ);
  assign lit_dec   = (lit_q != '0) ? lit_q - 1'b1 : lit_q;
  assign depth_dec = (depth_q != '0) ? depth_q - 1'b1 : depth_q;

  always_comb begin
    phase_d = phase_q;
    esc_d   = esc_q;
    depth_d = depth_q;
    curly_d = curly_q;
    lit_d   = lit_q;
    kind_d  = kind_q;
    ovf_d   = ovf_q;
    res_now = '{consumed: 1'b0, done: 1'b0, kind: kind_q, ovf: 1'b0};

    if (phase_q == PH_IDLE) begin
      res_now.kind = KIND_NONE;
      unique case (cls_i)
        CLS_NUL: ;
        CLS_SPACE: res_now.consumed = 1'b1;
        CLS_QUOTE: begin
          res_now.consumed = 1'b1;
          phase_d = PH_STR;
          kind_d  = KIND_STRING;
        end
        CLS_OPEN_SQ, CLS_OPEN_CURLY: begin
          res_now.consumed = 1'b1;
          phase_d = PH_BRK;
          depth_d = DepthOne;
          curly_d = (cls_i == CLS_OPEN_CURLY);
          kind_d  = (cls_i == CLS_OPEN_CURLY) ? KIND_OBJECT : KIND_ARRAY;
        end
        CLS_LIT_T: begin
          res_now.consumed = 1'b1;
          phase_d = PH_LIT;
          lit_d   = 3'd3;
          kind_d  = KIND_TRUE;
        end
        CLS_LIT_F: begin
          res_now.consumed = 1'b1;
          phase_d = PH_LIT;
          lit_d   = 3'd4;
          kind_d  = KIND_FALSE;
        end
        CLS_LIT_N: begin
          res_now.consumed = 1'b1;
          phase_d = PH_LIT;
          lit_d   = 3'd3;
          kind_d  = KIND_NULL;
        end
        CLS_COMMA, CLS_CLOSE_SQ, CLS_CLOSE_CURLY: begin
          // empty number: ends here, kind stays none
          res_now.done = 1'b1;
        end
        default: begin
          res_now.consumed = 1'b1;
          phase_d = PH_NUM;
          kind_d  = KIND_NUMBER;
        end
      endcase
      if (!res_now.done) begin
        res_now.kind = kind_d;
      end
    end else if (cls_i == CLS_NUL) begin
      res_now.done = 1'b1;
    end else begin
      unique case (phase_q)
        PH_STR: begin
          res_now.consumed = 1'b1;
          priority if (esc_q) begin
            esc_d = 1'b0;
          end else if (cls_i == CLS_BSLASH) begin
            esc_d = 1'b1;
          end else begin
            res_now.done = (cls_i == CLS_QUOTE);
          end
        end
        PH_BRKSTR: begin
          res_now.consumed = 1'b1;
          priority if (esc_q) begin
            esc_d = 1'b0;
          end else if (cls_i == CLS_BSLASH) begin
            esc_d = 1'b1;
          end else if (cls_i == CLS_QUOTE) begin
            phase_d = PH_BRK;
          end else begin
            // plain string byte: hold the phase
            phase_d = phase_q;
          end
        end
        PH_BRK: begin
          res_now.consumed = 1'b1;
          priority if (cls_i == CLS_QUOTE) begin
            phase_d = PH_BRKSTR;
            esc_d   = 1'b0;
          end else if (is_open) begin
            if (depth_q >= DepthMax) begin
              depth_d = DepthMax;
              ovf_d   = 1'b1;
            end else begin
              depth_d = depth_q + 1'b1;
            end
          end else if (is_close) begin
            depth_d      = depth_dec;
            res_now.done = (depth_dec == '0);
          end else begin
            // any other byte: hold the depth
            depth_d = depth_q;
          end
        end
        PH_LIT: begin
          res_now.consumed = 1'b1;
          lit_d            = lit_dec;
          res_now.done     = (lit_dec == '0);
        end
        PH_NUM: begin
          if ((cls_i == CLS_COMMA) || (cls_i == CLS_CLOSE_SQ) ||
              (cls_i == CLS_CLOSE_CURLY)) begin
            res_now.done = 1'b1;
          end else begin
            res_now.consumed = 1'b1;
          end
        end
        default: begin
          // unused phase code: drop back to idle
          phase_d      = PH_IDLE;
          esc_d        = 1'b0;
          depth_d      = '0;
          curly_d      = 1'b0;
          lit_d        = '0;
          kind_d       = KIND_NONE;
          ovf_d        = 1'b0;
          res_now.kind = KIND_NONE;
        end
      endcase
    end

    res_now.ovf = ovf_d;
    if (res_now.done) begin
      phase_d = PH_IDLE;
      esc_d   = 1'b0;
      depth_d = '0;
      curly_d = 1'b0;
      lit_d   = '0;
      kind_d  = KIND_NONE;
      ovf_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      esc_q       <= 1'b0;
      depth_q     <= '0;
      curly_q     <= 1'b0;
      lit_q       <= '0;
      kind_q      <= KIND_NONE;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        esc_q   <= esc_d;
        depth_q <= depth_d;
        curly_q <= curly_d;
        lit_q   <= lit_d;
        kind_q  <= kind_d;
        ovf_q   <= ovf_d;
      end
      if (cls_ready_o) begin
        out_valid_q <= cls_valid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= res_now;
    end
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

  `JVS_ASSERT(a_depth_bound, clk_i, rst_ni, depth_q <= DepthMax)
  `JVS_ASSERT(a_idle_clean, clk_i, rst_ni,
    (phase_q == PH_IDLE) |-> (depth_q == '0 && kind_q == KIND_NONE && !ovf_q))
  `JVS_ASSERT(a_lit_left, clk_i, rst_ni, (phase_q == PH_LIT) |-> (lit_q != '0))
  `JVS_ASSERT_RST(a_reset_idle, clk_i, rst_ni, phase_q == PH_IDLE)

endmodule

### src/json_value_skipper.sv
// Top level of the json value skipper: front classifier, queue, back FSM.
// Depends on jvs_pkg, jvs_front, jvs_queue and jvs_back.
//
// Usage: send JSON text one byte per word on the input channel
// (in_valid_i / in_ready_o, text_byte_i); byte 0 marks end of text.
// Every accepted word yields exactly one result word on the output channel
// (out_valid_o / out_ready_i) carrying consumed_o, done_res_o,
// value_kind_o and depth_overflow_o, in input order.
// Path: an accepted word moves through the front class register, the
// two-entry queue and the back output register, in that order.
// Throughput: one word per cycle while out_ready_i stays high. The back
// state update is a single small step per byte.
// Stalls: when the receiver holds out_ready_i low the output register holds
// its word, the queue fills, and then the front register and in_ready_o
// back up; the front keeps accepting while queue space remains.
// Reset: rst_ni clears all valid flags and puts the FSM in idle, skipping
// whitespace; no word is in flight after reset.
// MAX_NEST_DEPTH sets the saturation point and width of the nesting counter.
module json_value_skipper import jvs_pkg::*; #(
  parameter int MAX_NEST_DEPTH = DEF_MAX_NEST_DEPTH
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] text_byte_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic       consumed_o,
  output logic       done_res_o,
  output logic [2:0] value_kind_o,
  output logic       depth_overflow_o
);

  // front -> queue
  logic        fr_valid, fr_ready;
  byte_class_e fr_cls;
  // queue -> back
  logic        bk_valid, bk_ready;
  byte_class_e bk_cls;
  // back result word
  jvs_result_t res;

  jvs_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .text_byte_i (text_byte_i),
    .cls_valid_o (fr_valid),
    .cls_ready_i (fr_ready),
    .cls_o       (fr_cls)
  );

  jvs_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fr_valid),
    .push_ready_o (fr_ready),
    .push_cls_i   (fr_cls),
    .pop_valid_o  (bk_valid),
    .pop_ready_i  (bk_ready),
    .pop_cls_o    (bk_cls)
  );

  jvs_back #(
    .MAX_NEST_DEPTH (MAX_NEST_DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cls_valid_i (bk_valid),
    .cls_ready_o (bk_ready),
    .cls_i       (bk_cls),
    .res_valid_o (out_valid_o),
    .res_ready_i (out_ready_i),
    .res_o       (res)
  );

  // unpack the result word onto the payload ports
  assign consumed_o       = res.consumed;
  assign done_res_o       = res.done;
  assign value_kind_o     = res.kind;
  assign depth_overflow_o = res.ovf;

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// Testbench for json_value_skipper: directed and random JSON text, one byte per word.
// Depends on jvs_pkg and the json_value_skipper RTL; predicts every result word itself.
module testbench;
  import jvs_pkg::*;

  localparam int NEST_LIMIT     = DEF_MAX_NEST_DEPTH;
  localparam int RANDOM_BYTES   = 880;
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum logic [2:0] {
    SKIP_IDLE,
    SKIP_STRING,
    SKIP_BRACKET,
    SKIP_BRACKET_STRING,
    SKIP_LITERAL,
    SKIP_NUMBER
  } skip_phase_e;

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_ready_o;
  logic [7:0] text_byte_i;
  logic       out_valid_o;
  logic       out_ready_i;
  logic       consumed_o;
  logic       done_res_o;
  logic [2:0] value_kind_o;
  logic       depth_overflow_o;

  json_value_skipper #(
    .MAX_NEST_DEPTH(NEST_LIMIT)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .text_byte_i     (text_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .consumed_o      (consumed_o),
    .done_res_o      (done_res_o),
    .value_kind_o    (value_kind_o),
    .depth_overflow_o(depth_overflow_o)
  );

  // Predicted skipper state, mirrors the block after reset.
  skip_phase_e skip_phase   = SKIP_IDLE;
  logic        escape_armed = 1'b0;
  int          bracket_depth = 0;
  logic        curly_scope  = 1'b0;
  int          literal_bytes_left = 0;
  logic [2:0]  open_kind    = KIND_NONE;
  logic        nest_overflowed = 1'b0;

  jvs_result_t expected_results[$];
  jvs_result_t oldest_result;
  logic [7:0]  text_q[$];

  int   mismatches   = 0;
  int   quiet_cycles = 0;
  int   bytes_sent   = 0;
  int   burst_left   = 0;
  bit   tx_gaps_on   = 1'b1;
  bit   rx_stalls_on = 1'b1;
  int   rx_left      = 0;
  bit   rx_open      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic is_blank(input logic [7:0] b);
    return b == CHAR_SPACE || b == CHAR_TAB || b == CHAR_LF || b == CHAR_CR;
  endfunction

  function automatic logic ends_number(input logic [7:0] b);
    return b == CHAR_COMMA || b == CHAR_RSQ || b == CHAR_RCURLY;
  endfunction

  // Advance the string scanner by one byte; return 1 on the closing quote.
  function automatic logic string_closes(input logic [7:0] b);
    if (escape_armed) begin
      escape_armed = 1'b0;
      return 1'b0;
    end
    if (b == CHAR_BSLASH) begin
      escape_armed = 1'b1;
      return 1'b0;
    end
    return b == CHAR_QUOTE;
  endfunction

  function automatic void drop_value();
    skip_phase         = SKIP_IDLE;
    escape_armed       = 1'b0;
    bracket_depth      = 0;
    curly_scope        = 1'b0;
    literal_bytes_left = 0;
    open_kind          = KIND_NONE;
    nest_overflowed    = 1'b0;
  endfunction

  // Work out the result word for one text byte and update the predicted state.
  function automatic jvs_result_t predict_skip(input logic [7:0] b);
    jvs_result_t r;
    logic        ends;
    logic [7:0]  open_ch;
    logic [7:0]  close_ch;
    r        = '0;
    r.kind   = open_kind;
    ends     = 1'b0;
    if (skip_phase == SKIP_IDLE) begin
      r.kind = KIND_NONE;
      if (b == CHAR_NUL) begin
        // end of text while idle: nothing happens
      end else if (is_blank(b)) begin
        r.consumed = 1'b1;
      end else if (b == CHAR_QUOTE) begin
        r.consumed = 1'b1;
        skip_phase = SKIP_STRING;
        open_kind  = KIND_STRING;
      end else if (b == CHAR_LSQ || b == CHAR_LCURLY) begin
        r.consumed    = 1'b1;
        skip_phase    = SKIP_BRACKET;
        bracket_depth = 1;
        curly_scope   = (b == CHAR_LCURLY);
        open_kind     = curly_scope ? KIND_OBJECT : KIND_ARRAY;
      end else if (b == CHAR_T || b == CHAR_N) begin
        r.consumed         = 1'b1;
        skip_phase         = SKIP_LITERAL;
        literal_bytes_left = 3;
        open_kind          = (b == CHAR_T) ? KIND_TRUE : KIND_NULL;
      end else if (b == CHAR_F) begin
        r.consumed         = 1'b1;
        skip_phase         = SKIP_LITERAL;
        literal_bytes_left = 4;
        open_kind          = KIND_FALSE;
      end else if (ends_number(b)) begin
        // empty number: reported done, kind stays none on this word
        ends      = 1'b1;
        open_kind = KIND_NUMBER;
      end else begin
        r.consumed = 1'b1;
        skip_phase = SKIP_NUMBER;
        open_kind  = KIND_NUMBER;
      end
      if (!ends) r.kind = open_kind;
    end else if (b == CHAR_NUL) begin
      ends = 1'b1;
    end else begin
      case (skip_phase)
        SKIP_STRING: begin
          r.consumed = 1'b1;
          ends       = string_closes(b);
        end
        SKIP_BRACKET_STRING: begin
          r.consumed = 1'b1;
          if (string_closes(b)) skip_phase = SKIP_BRACKET;
        end
        SKIP_BRACKET: begin
          open_ch    = curly_scope ? CHAR_LCURLY : CHAR_LSQ;
          close_ch   = curly_scope ? CHAR_RCURLY : CHAR_RSQ;
          r.consumed = 1'b1;
          if (b == CHAR_QUOTE) begin
            skip_phase   = SKIP_BRACKET_STRING;
            escape_armed = 1'b0;
          end else if (b == open_ch) begin
            // saturate the depth and remember the overflow
            if (bracket_depth >= NEST_LIMIT) begin
              bracket_depth   = NEST_LIMIT;
              nest_overflowed = 1'b1;
            end else begin
              bracket_depth++;
            end
          end else if (b == close_ch) begin
            if (bracket_depth > 0) bracket_depth--;
            if (bracket_depth == 0) ends = 1'b1;
          end
        end
        SKIP_LITERAL: begin
          r.consumed = 1'b1;
          if (literal_bytes_left > 0) literal_bytes_left--;
          if (literal_bytes_left == 0) ends = 1'b1;
        end
        default: begin
          // number: the terminator is left unconsumed
          if (ends_number(b)) ends = 1'b1;
          else r.consumed = 1'b1;
        end
      endcase
    end
    r.done = ends;
    r.ovf  = nest_overflowed;
    if (ends && skip_phase != SKIP_IDLE) drop_value();
    else if (ends) open_kind = KIND_NONE;
    return r;
  endfunction

  task automatic check_field(input string field, input logic [2:0] want, input logic [2:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // Sample both channels on the falling edge before the edge that accepts the words.
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) expected_results.push_back(predict_skip(text_byte_i));
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result word with none expected, actual %b%b%0d%b", $time,
                   consumed_o, done_res_o, value_kind_o, depth_overflow_o);
          mismatches++;
        end else begin
          oldest_result = expected_results.pop_front();
          check_field("consumed", 3'(oldest_result.consumed), 3'(consumed_o));
          check_field("done_res", 3'(oldest_result.done), 3'(done_res_o));
          check_field("value_kind", oldest_result.kind, value_kind_o);
          check_field("depth_overflow", 3'(oldest_result.ovf), 3'(depth_overflow_o));
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
    end
  end

  // Receiver: alternate open and stalled runs of random length, or stay open while rx_stalls_on is clear.
  always @(posedge clk_i) begin
    if (rx_left > 0) begin
      rx_left--;
    end else begin
      rx_open     = !rx_open || !rx_stalls_on;
      rx_left     = rx_open ? $urandom_range(1, 16) : $urandom_range(1, 5);
      out_ready_i <= rx_open;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(negedge clk_i);
    $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  // Hold one word on the input channel until it is taken, then maybe open a gap.
  task automatic send_byte(input logic [7:0] b);
    logic taken;
    text_byte_i <= b;
    in_valid_i  <= 1'b1;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end
    bytes_sent++;
    if (burst_left > 0) burst_left--;
    if (tx_gaps_on && burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
  endtask

  task automatic send_text();
    while (text_q.size() != 0) send_byte(text_q.pop_front());
  endtask

  task automatic queue_str(input string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  // Drop valid and hold off until every expected result word has arrived.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] random_blank();
    case ($urandom_range(0, 3))
      0:       return CHAR_SPACE;
      1:       return CHAR_TAB;
      2:       return CHAR_LF;
      default: return CHAR_CR;
    endcase
  endfunction

  // Append one value to the text queue: mostly well formed, with random content.
  task automatic build_value(input int lvl);
    int         pick;
    int         n;
    logic       curly;
    logic [7:0] c;
    repeat ($urandom_range(0, 2)) text_q.push_back(random_blank());
    pick = (lvl >= 3) ? 0 : $urandom_range(0, (lvl == 0) ? 99 : 84);
    if (pick < 20) begin
      text_q.push_back(CHAR_QUOTE);
      repeat ($urandom_range(0, 6)) begin
        case ($urandom_range(0, 9))
          0: begin
            text_q.push_back(CHAR_BSLASH);
            text_q.push_back(8'($urandom_range(1, 255)));
          end
          1: text_q.push_back(8'($urandom_range(8'h80, 8'hff)));
          2: text_q.push_back($urandom_range(0, 1) ? CHAR_RSQ : CHAR_RCURLY);
          default: begin
            c = 8'($urandom_range(8'h20, 8'h7e));
            text_q.push_back((c == CHAR_QUOTE || c == CHAR_BSLASH) ? 8'h61 : c);
          end
        endcase
      end
      text_q.push_back(CHAR_QUOTE);
    end else if (pick < 45) begin
      curly = 1'($urandom_range(0, 1));
      text_q.push_back(curly ? CHAR_LCURLY : CHAR_LSQ);
      n = $urandom_range(0, 3);
      for (int i = 0; i < n; i++) begin
        if (i > 0) text_q.push_back(CHAR_COMMA);
        if (curly) queue_str("\"k\":");
        build_value(lvl + 1);
      end
      // the other bracket kind must not count
      if ($urandom_range(0, 3) == 0) text_q.push_back(curly ? CHAR_RSQ : CHAR_RCURLY);
      if ($urandom_range(0, 3) == 0) text_q.push_back(curly ? CHAR_LSQ : CHAR_LCURLY);
      text_q.push_back(curly ? CHAR_RCURLY : CHAR_RSQ);
    end else if (pick < 65) begin
      n = $urandom_range(0, 9);
      if (n == 0) begin
        // literal with arbitrary content, only the length matters
        text_q.push_back(CHAR_F);
        repeat (4) text_q.push_back(8'($urandom_range(1, 255)));
      end else if (n < 4) begin
        queue_str("true");
      end else if (n < 7) begin
        queue_str("false");
      end else begin
        queue_str("null");
      end
    end else if (pick < 85) begin
      if ($urandom_range(0, 1)) queue_str("-");
      repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(8'h30, 8'h39)));
      if ($urandom_range(0, 3) == 0) queue_str(".5e+3");
      if (lvl != 0) begin
        text_q.push_back(CHAR_COMMA);
      end else begin
        case ($urandom_range(0, 2))
          0:       text_q.push_back(CHAR_COMMA);
          1:       text_q.push_back(CHAR_RSQ);
          default: text_q.push_back(CHAR_RCURLY);
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 4)) text_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  task automatic test_idle_bytes();
    // end of text, whitespace and lone number terminators while idle
    text_q.push_back(CHAR_NUL);
    text_q.push_back(CHAR_SPACE);
    text_q.push_back(CHAR_TAB);
    text_q.push_back(CHAR_LF);
    text_q.push_back(CHAR_CR);
    text_q.push_back(CHAR_COMMA);
    text_q.push_back(CHAR_RSQ);
    text_q.push_back(CHAR_RCURLY);
    send_text();
  endtask

  task automatic test_value_kinds();
    queue_str("\"a\\\"b\\\\\"");
    queue_str("true");
    queue_str("nXY]");
    queue_str("-9e,");
    text_q.push_back(8'hff);
    text_q.push_back(8'h80);
    text_q.push_back(CHAR_RSQ);
    queue_str("{\"}\"[}");
    send_text();
    wait_drained();
  endtask

  task automatic test_end_of_text();
    // cut off a string after a backslash, a literal, an array and a number
    queue_str("\"\\");
    text_q.push_back(CHAR_NUL);
    queue_str("fa");
    text_q.push_back(CHAR_NUL);
    queue_str("[[");
    text_q.push_back(CHAR_NUL);
    queue_str("7");
    text_q.push_back(CHAR_NUL);
    send_text();
  endtask

  task automatic test_depth_saturation();
    repeat (NEST_LIMIT + 2) text_q.push_back(CHAR_LSQ);
    queue_str("\"]\"{}");
    repeat (NEST_LIMIT) text_q.push_back(CHAR_RSQ);
    repeat (NEST_LIMIT + 1) text_q.push_back(CHAR_LCURLY);
    text_q.push_back(CHAR_NUL);
    send_text();
    wait_drained();
  endtask

  task automatic test_random_text();
    int last_start;
    int cut;
    int goal;
    goal = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < goal) begin
      if ($urandom_range(0, 29) == 0) begin
        // reshuffle idling, sometimes into a stretch with none at all
        tx_gaps_on   = $urandom_range(0, 2) != 0;
        rx_stalls_on = tx_gaps_on ? $urandom_range(0, 3) != 0 : 1'b0;
      end
      last_start = text_q.size();
      build_value(0);
      if ($urandom_range(0, 24) == 0) begin
        cut = $urandom_range(last_start, text_q.size() - 1);
        while (text_q.size() > cut) void'(text_q.pop_back());
        text_q.push_back(CHAR_NUL);
      end
      send_text();
      if ($urandom_range(0, 49) == 0) wait_drained();
    end
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    text_byte_i = CHAR_NUL;
    out_ready_i = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_idle_bytes();
    test_value_kinds();
    test_end_of_text();
    test_depth_saturation();
    test_random_text();

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
+incdir+src
src/jvs_pkg.sv
src/jvs_front.sv
src/jvs_queue.sv
src/jvs_back.sv
src/json_value_skipper.sv
tb/sv/testbench.sv
